/* design/kct_pkg.sv */
// Package: shared types and constants of the keyed counter table.
package kct_pkg;

    localparam int unsigned KEY_BITS   = 257;   // kind bit + 256 key bits
    localparam int unsigned CNT_BITS   = 20;
    localparam int unsigned TOT_BITS   = 26;
    localparam int unsigned USED_BITS  = 7;
    localparam logic [CNT_BITS-1:0]  COUNT_MAX = 20'd999999;
    localparam logic [TOT_BITS-1:0]  TOT_FIELD_MAX = 26'h3FFFFFF;
    localparam logic [USED_BITS-1:0] USED_FIELD_MAX = 7'h7F;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_INC  = 2'd1,
        OP_CLR  = 2'd2,
        OP_LOOK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // One classified transaction handed from front to back.
    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [CNT_BITS-1:0] cnt;
        logic                cnt_bad;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EXEC,
        BK_SHIFT_RD,
        BK_SHIFT_WR,
        BK_DONE
    } bk_state_t;

endpackage

/* design/kct_ram.sv */
// Generic single-port RAM with registered read.
module kct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

/* design/kct_front.sv */
// Front end: takes commands, normalizes the key, checks the count, queues.
module kct_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                q_busy,
    input  logic [1:0]          operation,
    input  logic                key_kind,
    input  logic [63:0]         key_word0,
    input  logic [63:0]         key_word1,
    input  logic [63:0]         key_word2,
    input  logic [63:0]         key_word3,
    input  logic [19:0]         new_count,
    output logic                cmd_valid,
    output kct_pkg::cmd_t       cmd,
    input  logic                cmd_pop
);
    import kct_pkg::*;

    // One-entry queue between front and back.
    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    always_comb
    begin
        cmd_next.op  = op_t'(operation);
        cmd_next.cnt = new_count;
        cmd_next.cnt_bad = (new_count == '0) || (new_count > COUNT_MAX);
        if (key_kind)
        begin
            cmd_next.key = {1'b1, key_word3, key_word2, key_word1, key_word0};
        end
        else
        begin
            cmd_next.key = {1'b0, 192'd0, 32'd0, key_word0[31:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (start && !q_busy)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd_pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !q_busy)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;
endmodule

/* design/kct_back.sv */
// Back end: scans the table, updates entries and closes gaps on clear.
module kct_back #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  kct_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    output logic                idle,
    output logic                done,
    output logic [1:0]          status,
    output logic [19:0]         key_count,
    output logic [25:0]         total_count,
    output logic [6:0]          entries_used
);
    import kct_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW = $clog2(DEPTH + 1);
    localparam int unsigned TW = $clog2(DEPTH * 999999 + 1);
    localparam int unsigned EW = KEY_BITS + CNT_BITS;

    bk_state_t state_reg, state_next;
    logic [NW-1:0] used_reg, used_next;
    logic [TW-1:0] total_reg, total_next;
    logic [NW-1:0] idx_reg, idx_next;      // scan / shift pointer
    logic [NW-1:0] hit_reg, hit_next;
    logic          found_reg, found_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [1:0]    st_reg, st_next;
    logic [CNT_BITS-1:0] kc_reg, kc_next;
    logic [CNT_BITS-1:0] hcnt_reg, hcnt_next;
    logic          done_reg, done_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [EW-1:0] wdata, rdata;

    kct_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    logic [KEY_BITS-1:0] r_key;
    logic [CNT_BITS-1:0] r_cnt;
    assign r_key = rdata[EW-1:CNT_BITS];
    assign r_cnt = rdata[CNT_BITS-1:0];

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        rd_pend_next = 1'b0;
        st_next      = st_reg;
        kc_next      = kc_reg;
        hcnt_next    = hcnt_reg;
        done_next    = 1'b0;
        we           = 1'b0;
        addr         = idx_reg[AW-1:0];
        wdata        = {cmd.key, cmd.cnt};
        cmd_pop      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                // Read at idx issued this cycle, compared next cycle.
                if (rd_pend_reg && !found_reg && r_key == cmd.key)
                begin
                    found_next = 1'b1;
                    hit_next   = idx_reg - NW'(1);
                    hcnt_next  = r_cnt;
                    state_next = BK_EXEC;
                end
                else if (idx_reg >= used_reg)
                begin
                    state_next = BK_EXEC;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + NW'(1);
                end
            end
            BK_EXEC:
            begin
                st_next   = ST_OK;
                kc_next   = '0;
                state_next = BK_DONE;
                case (cmd.op)
                    OP_SET:
                    begin
                        if (cmd.cnt_bad)
                        begin
                            st_next = ST_BAD;
                            kc_next = found_reg ? hcnt_reg : '0;
                        end
                        else if (found_reg)
                        begin
                            st_next = ST_DUP;
                            kc_next = hcnt_reg;
                        end
                        else if (used_reg >= NW'(DEPTH))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            addr       = used_reg[AW-1:0];
                            used_next  = used_reg + NW'(1);
                            total_next = total_reg + TW'(cmd.cnt);
                            kc_next    = cmd.cnt;
                        end
                    end
                    OP_INC:
                    begin
                        if (found_reg)
                        begin
                            addr = hit_reg[AW-1:0];
                            if (hcnt_reg < COUNT_MAX)
                            begin
                                we         = 1'b1;
                                wdata      = {cmd.key, hcnt_reg + CNT_BITS'(1)};
                                total_next = total_reg + TW'(1);
                                kc_next    = hcnt_reg + CNT_BITS'(1);
                            end
                            else
                            begin
                                kc_next = hcnt_reg;
                            end
                        end
                        else if (used_reg >= NW'(DEPTH))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            addr       = used_reg[AW-1:0];
                            wdata      = {cmd.key, CNT_BITS'(1)};
                            used_next  = used_reg + NW'(1);
                            total_next = total_reg + TW'(1);
                            kc_next    = CNT_BITS'(1);
                        end
                    end
                    OP_CLR:
                    begin
                        if (found_reg)
                        begin
                            total_next = total_reg - TW'(hcnt_reg);
                            idx_next   = hit_reg + NW'(1);
                            state_next = BK_SHIFT_RD;
                        end
                    end
                    default:
                    begin
                        kc_next = found_reg ? hcnt_reg : '0;
                    end
                endcase
            end
            BK_SHIFT_RD:
            begin
                // idx points at the entry to move down one place.
                if (idx_reg >= used_reg)
                begin
                    used_next  = used_reg - NW'(1);
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_SHIFT_WR;
                end
            end
            BK_SHIFT_WR:
            begin
                we         = 1'b1;
                addr       = AW'(idx_reg - NW'(1));
                wdata      = rdata;
                idx_next   = idx_reg + NW'(1);
                state_next = BK_SHIFT_RD;
            end
            BK_DONE:
            begin
                done_next  = 1'b1;
                cmd_pop    = 1'b1;
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            used_reg    <= '0;
            total_reg   <= '0;
            done_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        st_reg   <= st_next;
        kc_reg   <= kc_next;
        hcnt_reg <= hcnt_next;
    end

    always_comb
    begin
        if ({{(32-TW){1'b0}}, total_reg} > 32'(TOT_FIELD_MAX))
        begin
            total_count = TOT_FIELD_MAX;
        end
        else
        begin
            total_count = TOT_BITS'(total_reg);
        end
        if ({{(32-NW){1'b0}}, used_reg} > 32'(USED_FIELD_MAX))
        begin
            entries_used = USED_FIELD_MAX;
        end
        else
        begin
            entries_used = USED_BITS'(used_reg);
        end
    end

    assign idle      = (state_reg == BK_IDLE);
    assign done      = done_reg;
    assign status    = st_reg;
    assign key_count = kc_reg;
endmodule

/* design/keyed_saturating_counter_table_unit.sv */
// Top level: keyed saturating counter table, front/back split around a queue.
// Each command scans the used entries over one RAM port, one entry per cycle,
// stopping at a hit; a clear then moves each later entry down one place,
// with a read state and a write state per entry moved.
// One transaction at a time; busy is high from accept until done strobes.
// done marks the result for one cycle; the receiver cannot stall.
// Reset empties the table (count zero); RAM contents need no clearing.
module keyed_saturating_counter_table_unit #(
    parameter int unsigned DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic        key_kind,
    input  logic [63:0] key_word0,
    input  logic [63:0] key_word1,
    input  logic [63:0] key_word2,
    input  logic [63:0] key_word3,
    input  logic [19:0] new_count,
    output logic        done,
    output logic [1:0]  status,
    output logic [19:0] key_count,
    output logic [25:0] total_count,
    output logic [6:0]  entries_used
);
    import kct_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic back_idle;

    // Busy while a transaction sits in the queue or the back end works.
    assign busy = cmd_valid || !back_idle;

    kct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .q_busy    (busy),
        .operation (operation),
        .key_kind  (key_kind),
        .key_word0 (key_word0),
        .key_word1 (key_word1),
        .key_word2 (key_word2),
        .key_word3 (key_word3),
        .new_count (new_count),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    kct_back #(.DEPTH(DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .idle         (back_idle),
        .done         (done),
        .status       (status),
        .key_count    (key_count),
        .total_count  (total_count),
        .entries_used (entries_used)
    );
endmodule

/* tb/keyed_saturating_counter_table_unit_tb.sv */
// Testbench for the keyed saturating counter table: directed table plus random traffic.
module keyed_saturating_counter_table_unit_tb;
    import kct_pkg::*;

    localparam int TBL_DEPTH  = 64;
    localparam int WDOG_LIMIT = 20000;
    localparam int NUM_RANDOM = 1750;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = '0;
    logic        key_kind = 1'b0;
    logic [63:0] key_word0 = '0;
    logic [63:0] key_word1 = '0;
    logic [63:0] key_word2 = '0;
    logic [63:0] key_word3 = '0;
    logic [19:0] new_count = '0;
    logic        done;
    logic [1:0]  status;
    logic [19:0] key_count;
    logic [25:0] total_count;
    logic [6:0]  entries_used;

    keyed_saturating_counter_table_unit #(.DEPTH(TBL_DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .key_kind(key_kind),
        .key_word0(key_word0), .key_word1(key_word1),
        .key_word2(key_word2), .key_word3(key_word3),
        .new_count(new_count), .done(done), .status(status),
        .key_count(key_count), .total_count(total_count),
        .entries_used(entries_used)
    );

    always #5 clk = ~clk;

    typedef struct {
        op_t         op;
        logic        kind;
        logic [63:0] w0, w1, w2, w3;
        logic [19:0] cnt;
    } cmd_item_t;

    typedef struct {
        status_t     st;
        logic [19:0] kc;
        logic [25:0] tot;
        logic [6:0]  used;
    } table_result_t;

    // Shadow copy of the table, kept in insertion order.
    logic         shadow_kind [TBL_DEPTH];
    logic [255:0] shadow_key [TBL_DEPTH];
    logic [19:0]  shadow_cnt [TBL_DEPTH];
    int           shadow_used = 0;
    int           shadow_total = 0;

    table_result_t pending_results[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  sender_idle_pct = 0;

    // Key pool so random traffic hits existing entries often.
    cmd_item_t key_pool[$];

    function automatic table_result_t apply_table_op(cmd_item_t c);
        table_result_t r;
        logic [255:0]  k;
        int idx;
        r.st = ST_OK;
        r.kc = '0;
        // numeric keys keep only bits 31..0
        k = c.kind ? {c.w3, c.w2, c.w1, c.w0} : {224'd0, c.w0[31:0]};
        idx = -1;
        for (int i = 0; i < shadow_used; i++)
            if (idx < 0 && shadow_kind[i] == c.kind && shadow_key[i] == k)
                idx = i;
        case (c.op)
            OP_SET:
            begin
                if (c.cnt == 0 || c.cnt > COUNT_MAX)
                begin
                    r.st = ST_BAD;
                    if (idx >= 0) r.kc = shadow_cnt[idx];
                end
                else if (idx >= 0)
                begin
                    r.st = ST_DUP;
                    r.kc = shadow_cnt[idx];
                end
                else if (shadow_used >= TBL_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    shadow_kind[shadow_used] = c.kind;
                    shadow_key[shadow_used] = k;
                    shadow_cnt[shadow_used] = c.cnt;
                    shadow_used++;
                    shadow_total += c.cnt;
                    r.kc = c.cnt;
                end
            end
            OP_INC:
            begin
                if (idx >= 0)
                begin
                    if (shadow_cnt[idx] < COUNT_MAX)
                    begin
                        shadow_cnt[idx]++;
                        shadow_total++;
                    end
                    r.kc = shadow_cnt[idx];
                end
                else if (shadow_used >= TBL_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    shadow_kind[shadow_used] = c.kind;
                    shadow_key[shadow_used] = k;
                    shadow_cnt[shadow_used] = 20'd1;
                    shadow_used++;
                    shadow_total++;
                    r.kc = 20'd1;
                end
            end
            OP_CLR:
            begin
                if (idx >= 0)
                begin
                    shadow_total -= shadow_cnt[idx];
                    for (int i = idx; i + 1 < shadow_used; i++)
                    begin
                        shadow_kind[i] = shadow_kind[i + 1];
                        shadow_key[i] = shadow_key[i + 1];
                        shadow_cnt[i] = shadow_cnt[i + 1];
                    end
                    shadow_used--;
                end
            end
            default:
                if (idx >= 0) r.kc = shadow_cnt[idx];
        endcase
        r.tot = shadow_total[25:0];
        r.used = shadow_used[6:0];
        return r;
    endfunction

    // Drive one transaction, holding start until the block accepts it.
    // start stays high after the accept; a drain, or an idle gap in the next call, drops it.
    task automatic issue_cmd(cmd_item_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operation <= c.op;
        key_kind <= c.kind;
        key_word0 <= c.w0;
        key_word1 <= c.w1;
        key_word2 <= c.w2;
        key_word3 <= c.w3;
        new_count <= c.cnt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_table_op(c));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Result checker: done is a one-cycle strobe, sampled at the edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            table_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding");
                mismatches++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status);
                    mismatches++;
                end
                if (key_count !== e.kc)
                begin
                    $error("key_count exp %0d got %0d", e.kc, key_count);
                    mismatches++;
                end
                if (total_count !== e.tot)
                begin
                    $error("total_count exp %0d got %0d", e.tot, total_count);
                    mismatches++;
                end
                if (entries_used !== e.used)
                begin
                    $error("entries_used exp %0d got %0d", e.used, entries_used);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles with neither an accept nor a result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic cmd_item_t mk_cmd(op_t op, logic kind, logic [63:0] w0,
                                         logic [63:0] wx, logic [19:0] cnt);
        cmd_item_t c;
        c.op = op; c.kind = kind; c.w0 = w0;
        c.w1 = wx; c.w2 = ~wx; c.w3 = wx ^ 64'h5A5A;
        c.cnt = cnt;
        return c;
    endfunction

    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        int sel;
        c.kind = 1'($urandom_range(1));
        c.w0 = {$urandom, $urandom};
        c.w1 = {$urandom, $urandom};
        c.w2 = {$urandom, $urandom};
        c.w3 = {$urandom, $urandom};
        // reuse a pooled key most of the time, sometimes flipping only junk bits
        if (key_pool.size() != 0 && $urandom_range(99) < 70)
        begin
            cmd_item_t p;
            p = key_pool[$urandom_range(key_pool.size() - 1)];
            c.kind = p.kind; c.w0 = p.w0; c.w1 = p.w1; c.w2 = p.w2; c.w3 = p.w3;
            if (!c.kind && $urandom_range(1))
            begin
                c.w0[63:32] = $urandom;
                c.w1 = {$urandom, $urandom};
            end
        end
        else if (key_pool.size() < 90)
            key_pool.push_back(c);
        sel = $urandom_range(99);
        c.op = sel < 30 ? OP_SET : sel < 65 ? OP_INC : sel < 80 ? OP_CLR : OP_LOOK;
        sel = $urandom_range(9);
        c.cnt = sel == 0 ? 20'd0 : sel == 1 ? 20'(1000000 + $urandom_range(48575)) :
                sel == 2 ? COUNT_MAX - 20'($urandom_range(2)) : 20'($urandom_range(1, 999999));
        return c;
    endfunction

    // Directed rows; has_exp marks results that are written out by hand.
    typedef struct {
        cmd_item_t     c;
        bit            has_exp;
        table_result_t r;
    } directed_row_t;

    directed_row_t directed_rows[$];

    task automatic add_row(cmd_item_t c, bit has_exp, status_t st, int kc, int tot, int used);
        directed_row_t d;
        d.c = c; d.has_exp = has_exp;
        d.r.st = st; d.r.kc = 20'(kc); d.r.tot = 26'(tot); d.r.used = 7'(used);
        directed_rows.push_back(d);
    endtask

    initial
    begin
        table_result_t got;
        // Empty table after reset
        add_row(mk_cmd(OP_LOOK, 1'b0, 64'd7, 64'd0, 20'd0), 1, ST_OK, 0, 0, 0);
        add_row(mk_cmd(OP_CLR, 1'b1, 64'd7, 64'd1, 20'd0), 1, ST_OK, 0, 0, 0);
        // Bad counts: zero, just over the maximum, and all ones
        add_row(mk_cmd(OP_SET, 1'b0, 64'd7, 64'd0, 20'd0), 1, ST_BAD, 0, 0, 0);
        add_row(mk_cmd(OP_SET, 1'b0, 64'd7, 64'd0, 20'd1000000), 1, ST_BAD, 0, 0, 0);
        add_row(mk_cmd(OP_SET, 1'b0, 64'd7, 64'd0, 20'hFFFFF), 1, ST_BAD, 0, 0, 0);
        // Max count, then saturating increment
        add_row(mk_cmd(OP_SET, 1'b0, 64'd7, 64'd0, COUNT_MAX), 1, ST_OK, 999999, 999999, 1);
        add_row(mk_cmd(OP_INC, 1'b0, 64'd7, 64'd0, 20'd0), 1, ST_OK, 999999, 999999, 1);
        // Numeric key ignores upper bits: same key, duplicate
        add_row(mk_cmd(OP_SET, 1'b0, 64'hFFFF_FFFF_0000_0007, '1, 20'd5), 1,
                ST_DUP, 999999, 999999, 1);
        // Same low bits as a hash key is a different key
        add_row(mk_cmd(OP_INC, 1'b1, 64'd7, 64'd0, 20'd0), 1, ST_OK, 1, 1000000, 2);
        add_row(mk_cmd(OP_SET, 1'b1, '1, '1, 20'd1), 1, ST_OK, 1, 1000001, 3);
        add_row(mk_cmd(OP_SET, 1'b0, 64'hFFFF_FFFF, 64'd0, 20'd1000), 0, ST_OK, 0, 0, 0);
        add_row(mk_cmd(OP_INC, 1'b0, 64'hFFFF_FFFF, 64'd0, 20'd0), 0, ST_OK, 0, 0, 0);
        // Bad count on a present key reports its count
        add_row(mk_cmd(OP_SET, 1'b1, '1, '1, 20'd0), 0, ST_OK, 0, 0, 0);
        // Clear from the middle shifts later entries
        add_row(mk_cmd(OP_CLR, 1'b1, 64'd7, 64'd0, 20'd0), 0, ST_OK, 0, 0, 0);
        add_row(mk_cmd(OP_LOOK, 1'b1, '1, '1, 20'd0), 0, ST_OK, 0, 0, 0);
        add_row(mk_cmd(OP_LOOK, 1'b0, 64'hFFFF_FFFF, 64'd0, 20'd0), 0, ST_OK, 0, 0, 0);
        add_row(mk_cmd(OP_CLR, 1'b0, 64'd7, 64'd0, 20'd0), 0, ST_OK, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            issue_cmd(directed_rows[i].c);
            got = pending_results[$];
            // predictor must agree with the hand-typed values
            if (directed_rows[i].has_exp && got != directed_rows[i].r)
            begin
                $error("directed row %0d: predictor disagrees with expected", i);
                mismatches++;
            end
        end
        drain_results();

        // Fill the table to full, then try full-table set and increment
        for (int i = 0; i < TBL_DEPTH + 2; i++)
            issue_cmd(mk_cmd(OP_INC, 1'b1, 64'(i + 100), 64'(i), 20'd0));
        issue_cmd(mk_cmd(OP_SET, 1'b0, 64'd99999, 64'd0, 20'd3));
        // Clear the second entry with the table full
        issue_cmd(mk_cmd(OP_CLR, 1'b0, 64'hFFFF_FFFF, 64'd0, 20'd0));
        drain_results();

        // Random phases: no idle, mostly idle, a mix, and no idle again
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = ph == 0 ? 0 : ph == 1 ? 88 : ph == 2 ? 27 : 0;
            for (int n = 0; n < NUM_RANDOM / 4; n++)
            begin
                // occasionally wait for all outstanding results before going on
                issue_cmd(random_cmd());
                if ($urandom_range(199) == 0)
                    drain_results();
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* filelist.f */
design/kct_pkg.sv
design/kct_ram.sv
design/kct_front.sv
design/kct_back.sv
design/keyed_saturating_counter_table_unit.sv
tb/keyed_saturating_counter_table_unit_tb.sv
